FILE: design/hart_pkg.sv
// Shared constants, types and fixed-point helpers for the hinge axis transform.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package hart_pkg;

    typedef logic signed [31:0] q30_t;
    typedef logic signed [39:0] q16w_t;

    localparam int SQRT_STAGES   = 32;
    localparam int DIV_STAGES    = 31;
    localparam int CORDIC_STAGES = 34;
    localparam int MAT_STAGES    = 6;

    localparam logic signed [35:0] Q30_ONE  = 36'sd1073741824;
    localparam logic signed [35:0] Q30_PI   = 36'sd3373259426;
    localparam logic signed [35:0] Q30_2PI  = 36'sd6746518852;
    localparam logic signed [35:0] Q30_HPI  = 36'sd1686629713;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q30 product, rounded half up.
    function automatic logic signed [65:0] mul30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] prod;
        prod = 66'(a) * 66'(b);
        return (prod + 66'sd536870912) >>> 30;
    endfunction

endpackage

`default_nettype wire

FILE: design/hart_sqrt.sv
// Pipelined integer square root of a 64-bit radicand, one root bit per stage.
// Depends on hart_pkg for the stage count.
`default_nettype none

module hart_sqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    localparam int N = hart_pkg::SQRT_STAGES;

    logic [63:0] rem_reg  [N];
    logic [63:0] res_reg  [N];
    logic [63:0] rem_next [N];
    logic [63:0] res_next [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            logic [63:0] rem_p;
            logic [63:0] res_p;
            logic [63:0] bitv;
            logic [64:0] trial;
            bitv  = 64'd1 << (62 - 2 * i);
            rem_p = (i == 0) ? radicand : rem_reg[(i == 0) ? 0 : i - 1];
            res_p = (i == 0) ? 64'd0    : res_reg[(i == 0) ? 0 : i - 1];
            trial = {1'b0, res_p} + {1'b0, bitv};
            if ({1'b0, rem_p} >= trial)
            begin
                rem_next[i] = rem_p - trial[63:0];
                res_next[i] = (res_p >> 1) + bitv;
            end
            else
            begin
                rem_next[i] = rem_p;
                res_next[i] = res_p >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            rem_reg[i] <= rem_next[i];
            res_reg[i] <= res_next[i];
        end
    end

    assign root = res_reg[N-1][31:0];

endmodule

`default_nettype wire

FILE: design/hart_div.sv
// Pipelined restoring divider: 63-bit dividend over 32-bit divisor, 31-bit quotient.
// Depends on hart_pkg for the stage count.
`default_nettype none

module hart_div (
    input  logic        clk,
    input  logic [62:0] dividend,
    input  logic [31:0] divisor,
    output logic [30:0] quotient
);

    localparam int N = hart_pkg::DIV_STAGES;

    logic [31:0] rem_reg  [N];
    logic [30:0] lo_reg   [N];
    logic [30:0] quo_reg  [N];
    logic [31:0] den_reg  [N];
    logic [31:0] rem_next [N];
    logic [30:0] lo_next  [N];
    logic [30:0] quo_next [N];
    logic [31:0] den_next [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            logic [31:0] rem_p;
            logic [30:0] lo_p;
            logic [30:0] quo_p;
            logic [31:0] den_p;
            logic [32:0] trial;
            logic        ge;
            rem_p = (i == 0) ? dividend[62:31] : rem_reg[(i == 0) ? 0 : i - 1];
            lo_p  = (i == 0) ? dividend[30:0]  : lo_reg[(i == 0) ? 0 : i - 1];
            quo_p = (i == 0) ? 31'd0           : quo_reg[(i == 0) ? 0 : i - 1];
            den_p = (i == 0) ? divisor         : den_reg[(i == 0) ? 0 : i - 1];
            trial = {rem_p, lo_p[30]};
            ge    = (trial >= {1'b0, den_p});
            rem_next[i] = ge ? 32'(trial - {1'b0, den_p}) : trial[31:0];
            lo_next[i]  = {lo_p[29:0], 1'b0};
            quo_next[i] = {quo_p[29:0], ge};
            den_next[i] = den_p;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            rem_reg[i] <= rem_next[i];
            lo_reg[i]  <= lo_next[i];
            quo_reg[i] <= quo_next[i];
            den_reg[i] <= den_next[i];
        end
    end

    assign quotient = quo_reg[N-1];

endmodule

`default_nettype wire

FILE: design/hart_cordic.sv
// Angle reduction and 32-step rotation-mode CORDIC giving cosine and sine in Q2.30.
// Depends on hart_pkg for angle constants and the arctangent table.
`default_nettype none

module hart_cordic (
    input  logic                clk,
    input  logic signed [31:0]  angle,
    output hart_pkg::q30_t      cosine,
    output hart_pkg::q30_t      sine
);

    localparam int N = 32;

    logic signed [35:0] a1_reg;
    logic signed [33:0] z2_reg;
    logic               neg2_reg;

    logic signed [33:0] x_reg  [N];
    logic signed [33:0] y_reg  [N];
    logic signed [33:0] z_reg  [N];
    logic               neg_reg [N];
    logic signed [33:0] x_next [N];
    logic signed [33:0] y_next [N];
    logic signed [33:0] z_next [N];

    logic signed [35:0] a0;
    logic signed [35:0] a1_next;
    logic signed [35:0] z2_wide;
    logic               neg2_next;

    // Reduce by a full turn, then fold by a half turn.
    always_comb
    begin
        a0 = {{2{angle[31]}}, angle, 2'b00};
        if (a0 > hart_pkg::Q30_PI)
            a1_next = a0 - hart_pkg::Q30_2PI;
        else if (a0 < -hart_pkg::Q30_PI)
            a1_next = a0 + hart_pkg::Q30_2PI;
        else
            a1_next = a0;

        neg2_next = 1'b0;
        z2_wide   = a1_reg;
        if (a1_reg > hart_pkg::Q30_HPI)
        begin
            z2_wide   = a1_reg - hart_pkg::Q30_PI;
            neg2_next = 1'b1;
        end
        else if (a1_reg < -hart_pkg::Q30_HPI)
        begin
            z2_wide   = a1_reg + hart_pkg::Q30_PI;
            neg2_next = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            logic signed [33:0] xp;
            logic signed [33:0] yp;
            logic signed [33:0] zp;
            logic signed [33:0] xs;
            logic signed [33:0] ys;
            logic signed [33:0] at;
            xp = (i == 0) ? hart_pkg::CORDIC_K : x_reg[(i == 0) ? 0 : i - 1];
            yp = (i == 0) ? 34'sd0             : y_reg[(i == 0) ? 0 : i - 1];
            zp = (i == 0) ? z2_reg             : z_reg[(i == 0) ? 0 : i - 1];
            xs = xp >>> i;
            ys = yp >>> i;
            at = $signed({2'b00, hart_pkg::atan_q30(5'(i))});
            if (!zp[33])
            begin
                x_next[i] = xp - ys;
                y_next[i] = yp + xs;
                z_next[i] = zp - at;
            end
            else
            begin
                x_next[i] = xp + ys;
                y_next[i] = yp - xs;
                z_next[i] = zp + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg   <= a1_next;
        z2_reg   <= 34'(z2_wide);
        neg2_reg <= neg2_next;
        for (int i = 0; i < N; i++)
        begin
            x_reg[i]   <= x_next[i];
            y_reg[i]   <= y_next[i];
            z_reg[i]   <= z_next[i];
            neg_reg[i] <= (i == 0) ? neg2_reg : neg_reg[(i == 0) ? 0 : i - 1];
        end
    end

    // The fold negates both outputs.
    assign cosine = neg_reg[N-1] ? 32'(-x_reg[N-1]) : 32'(x_reg[N-1]);
    assign sine   = neg_reg[N-1] ? 32'(-y_reg[N-1]) : 32'(y_reg[N-1]);

endmodule

`default_nettype wire

FILE: design/hart_matrix.sv
// Rodrigues matrix assembly, saturation and translation p - R*p, six register stages.
// Depends on hart_pkg for the Q30 product helper and types.
`default_nettype none

module hart_matrix (
    input  logic                clk,
    input  logic [30:0]         quotient [3],
    input  logic [2:0]          sign,
    input  hart_pkg::q30_t      cosine,
    input  hart_pkg::q30_t      sine,
    input  logic signed [31:0]  point [3],
    input  logic                zero,
    output hart_pkg::q30_t      rot [9],
    output hart_pkg::q16w_t     shift [3]
);

    // Stage 0: signed unit vector and 1 - cos.
    logic signed [31:0] n0_reg  [3];
    logic signed [32:0] cc0_reg;
    logic signed [31:0] c0_reg;
    logic signed [31:0] s0_reg;
    logic signed [31:0] p0_reg  [3];
    logic               z0_reg;

    // Stage 1: n_i*n_j (order 00 11 22 01 02 12) and n_k*s.
    logic signed [31:0] nn1_reg [6];
    logic signed [31:0] ns1_reg [3];
    logic signed [32:0] cc1_reg;
    logic signed [31:0] c1_reg;
    logic signed [31:0] p1_reg  [3];
    logic               z1_reg;

    // Stage 2: times (1 - cos).
    logic signed [32:0] pc2_reg [6];
    logic signed [31:0] ns2_reg [3];
    logic signed [31:0] c2_reg;
    logic signed [31:0] p2_reg  [3];
    logic               z2_reg;

    // Stage 3: saturated matrix.
    logic signed [31:0] r3_reg  [9];
    logic signed [31:0] p3_reg  [3];
    logic               z3_reg;

    // Stage 4: R_ij * p_j terms.
    logic signed [33:0] tm4_reg [9];
    logic signed [31:0] r4_reg  [9];
    logic signed [31:0] p4_reg  [3];
    logic               z4_reg;

    // Stage 5: outputs.
    logic signed [31:0] r5_reg  [9];
    logic signed [39:0] t5_reg  [3];

    logic signed [34:0] e3 [9];
    logic signed [31:0] r3_next [9];
    logic signed [35:0] t5_sum [3];

    localparam int NI [6] = '{0, 1, 2, 0, 0, 1};
    localparam int NJ [6] = '{0, 1, 2, 1, 2, 2};

    always_comb
    begin
        e3[0] = 35'(pc2_reg[0]) + 35'(c2_reg);
        e3[4] = 35'(pc2_reg[1]) + 35'(c2_reg);
        e3[8] = 35'(pc2_reg[2]) + 35'(c2_reg);
        e3[1] = 35'(pc2_reg[3]) - 35'(ns2_reg[2]);
        e3[3] = 35'(pc2_reg[3]) + 35'(ns2_reg[2]);
        e3[2] = 35'(pc2_reg[4]) + 35'(ns2_reg[1]);
        e3[6] = 35'(pc2_reg[4]) - 35'(ns2_reg[1]);
        e3[5] = 35'(pc2_reg[5]) - 35'(ns2_reg[0]);
        e3[7] = 35'(pc2_reg[5]) + 35'(ns2_reg[0]);
        for (int i = 0; i < 9; i++)
        begin
            if (z2_reg)
                r3_next[i] = (i % 4 == 0) ? 32'sd1073741824 : 32'sd0;
            else if (e3[i] > 35'sd2147483647)
                r3_next[i] = 32'sh7FFFFFFF;
            else if (e3[i] < -35'sd2147483648)
                r3_next[i] = 32'sh80000000;
            else
                r3_next[i] = 32'(e3[i]);
        end
        for (int i = 0; i < 3; i++)
            t5_sum[i] = 36'(p4_reg[i]) - 36'(tm4_reg[3*i]) - 36'(tm4_reg[3*i+1])
                        - 36'(tm4_reg[3*i+2]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            n0_reg[i] <= sign[i] ? -$signed({1'b0, quotient[i]}) : $signed({1'b0, quotient[i]});
        cc0_reg <= 33'sd1073741824 - 33'(cosine);
        c0_reg  <= cosine;
        s0_reg  <= sine;
        p0_reg  <= point;
        z0_reg  <= zero;

        for (int k = 0; k < 6; k++)
            nn1_reg[k] <= 32'(hart_pkg::mul30(33'(n0_reg[NI[k]]), 33'(n0_reg[NJ[k]])));
        for (int i = 0; i < 3; i++)
            ns1_reg[i] <= 32'(hart_pkg::mul30(33'(n0_reg[i]), 33'(s0_reg)));
        cc1_reg <= cc0_reg;
        c1_reg  <= c0_reg;
        p1_reg  <= p0_reg;
        z1_reg  <= z0_reg;

        for (int k = 0; k < 6; k++)
            pc2_reg[k] <= 33'(hart_pkg::mul30(33'(nn1_reg[k]), cc1_reg));
        ns2_reg <= ns1_reg;
        c2_reg  <= c1_reg;
        p2_reg  <= p1_reg;
        z2_reg  <= z1_reg;

        r3_reg <= r3_next;
        p3_reg <= p2_reg;
        z3_reg <= z2_reg;

        for (int i = 0; i < 9; i++)
            tm4_reg[i] <= 34'(hart_pkg::mul30(33'(r3_reg[i]), 33'(p3_reg[i % 3])));
        r4_reg <= r3_reg;
        p4_reg <= p3_reg;
        z4_reg <= z3_reg;

        r5_reg <= r4_reg;
        for (int i = 0; i < 3; i++)
            t5_reg[i] <= z4_reg ? 40'sd0 : 40'(t5_sum[i]);
    end

    assign rot   = r5_reg;
    assign shift = t5_reg;

endmodule

`default_nettype wire

FILE: design/hinge_axis_rigid_transform.sv
// The result of each accepted start is taken when done is high.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Start runs to done through 5 front-end stages, the 32-stage root, a numerator stage,
// the 31-stage quotient and 6 matrix stages in series.
// Reset clears only the valid chain; no result strobes until a transaction runs through.
// Depends on hart_pkg, hart_sqrt, hart_div, hart_cordic and hart_matrix.
`default_nettype none

module hinge_axis_rigid_transform (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  logic signed [31:0]  turn_angle,
    output logic                done,
    output logic signed [31:0]  r00,
    output logic signed [31:0]  r01,
    output logic signed [31:0]  r02,
    output logic signed [31:0]  r10,
    output logic signed [31:0]  r11,
    output logic signed [31:0]  r12,
    output logic signed [31:0]  r20,
    output logic signed [31:0]  r21,
    output logic signed [31:0]  r22,
    output logic signed [39:0]  shift_x,
    output logic signed [39:0]  shift_y,
    output logic signed [39:0]  shift_z
);

    localparam int SQ   = hart_pkg::SQRT_STAGES;
    localparam int DV   = hart_pkg::DIV_STAGES;
    localparam int CR   = hart_pkg::CORDIC_STAGES;
    localparam int MT   = hart_pkg::MAT_STAGES;
    // Front end to divider output: 5 stages, root, numerator stage, quotient.
    localparam int T_Q  = 5 + SQ + 1 + DV;
    localparam int LAT  = T_Q + MT;
    localparam int P_DLY = T_Q - 1;
    localparam int Z_DLY = T_Q - 2;
    localparam int S_DLY = T_Q - 5;
    localparam int C_DLY = T_Q - 1 - CR;

    logic [LAT-1:0] valid_reg;

    logic signed [31:0] pt_reg  [3];
    logic signed [31:0] dir_reg [3];
    logic signed [31:0] ang_reg;

    logic [31:0] mag_c    [3];
    logic [63:0] sq2_reg  [3];
    logic [31:0] mag2_reg [3];
    logic [2:0]  sgn2_reg;
    logic        zero2_reg;

    logic [63:0] sum3_reg;
    logic [31:0] mag3_reg [3];
    logic [2:0]  sgn3_reg;

    logic [4:0]  k_c;
    logic [4:0]  k4_reg;
    logic [63:0] sum4_reg;
    logic [31:0] mag4_reg [3];
    logic [2:0]  sgn4_reg;

    logic [63:0] ssum5_reg;
    logic [31:0] msh5_reg [3];
    logic [2:0]  sgn5_reg;

    logic [31:0] root;
    logic [31:0] msh_dly_reg [SQ][3];
    logic [62:0] num_reg [3];
    logic [31:0] den_reg;
    logic [30:0] quo [3];

    logic signed [31:0] p_dly_reg [P_DLY][3];
    logic               zero_dly_reg [Z_DLY];
    logic [2:0]         sgn_dly_reg [S_DLY];

    hart_pkg::q30_t     cosine;
    hart_pkg::q30_t     sine;
    logic [63:0]        cs_dly_reg [C_DLY];

    hart_pkg::q30_t     rot [9];
    hart_pkg::q16w_t    shift [3];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-2:0], start & ~busy};
    end

    assign done = valid_reg[LAT-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag_c[i] = dir_reg[i][31] ? 32'(-dir_reg[i]) : 32'(dir_reg[i]);
        // Count leading zero bit pairs, capped at 31.
        k_c = 5'd31;
        for (int j = 30; j >= 0; j--)
            if (sum3_reg[63 - 2*j -: 2] != 2'b00)
                k_c = 5'(j);
    end

    always_ff @(posedge clk)
    begin
        pt_reg[0]  <= point_x;
        pt_reg[1]  <= point_y;
        pt_reg[2]  <= point_z;
        dir_reg[0] <= dir_x;
        dir_reg[1] <= dir_y;
        dir_reg[2] <= dir_z;
        ang_reg    <= turn_angle;

        for (int i = 0; i < 3; i++)
        begin
            sq2_reg[i]  <= 64'(mag_c[i]) * 64'(mag_c[i]);
            mag2_reg[i] <= mag_c[i];
            sgn2_reg[i] <= dir_reg[i][31];
        end
        zero2_reg <= (dir_reg[0] == 32'sd0) && (dir_reg[1] == 32'sd0) && (dir_reg[2] == 32'sd0);

        sum3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        mag3_reg <= mag2_reg;
        sgn3_reg <= sgn2_reg;

        k4_reg   <= k_c;
        sum4_reg <= sum3_reg;
        mag4_reg <= mag3_reg;
        sgn4_reg <= sgn3_reg;

        ssum5_reg <= sum4_reg << {k4_reg, 1'b0};
        for (int i = 0; i < 3; i++)
            msh5_reg[i] <= 32'(64'(mag4_reg[i]) << k4_reg);
        sgn5_reg <= sgn4_reg;

        // Hold the scaled magnitudes alongside the root pipeline.
        msh_dly_reg[0] <= msh5_reg;
        for (int j = 1; j < SQ; j++)
            msh_dly_reg[j] <= msh_dly_reg[j-1];

        // Round to nearest: add half the divisor.
        for (int i = 0; i < 3; i++)
            num_reg[i] <= 63'({msh_dly_reg[SQ-1][i], 30'd0}) + 63'(root[31:1]);
        den_reg <= root;

        p_dly_reg[0] <= pt_reg;
        for (int j = 1; j < P_DLY; j++)
            p_dly_reg[j] <= p_dly_reg[j-1];

        zero_dly_reg[0] <= zero2_reg;
        for (int j = 1; j < Z_DLY; j++)
            zero_dly_reg[j] <= zero_dly_reg[j-1];

        sgn_dly_reg[0] <= sgn5_reg;
        for (int j = 1; j < S_DLY; j++)
            sgn_dly_reg[j] <= sgn_dly_reg[j-1];

        cs_dly_reg[0] <= {cosine, sine};
        for (int j = 1; j < C_DLY; j++)
            cs_dly_reg[j] <= cs_dly_reg[j-1];
    end

    hart_sqrt u_sqrt (
        .clk      (clk),
        .radicand (ssum5_reg),
        .root     (root)
    );

    hart_div u_div_x (
        .clk      (clk),
        .dividend (num_reg[0]),
        .divisor  (den_reg),
        .quotient (quo[0])
    );

    hart_div u_div_y (
        .clk      (clk),
        .dividend (num_reg[1]),
        .divisor  (den_reg),
        .quotient (quo[1])
    );

    hart_div u_div_z (
        .clk      (clk),
        .dividend (num_reg[2]),
        .divisor  (den_reg),
        .quotient (quo[2])
    );

    hart_cordic u_cordic (
        .clk    (clk),
        .angle  (ang_reg),
        .cosine (cosine),
        .sine   (sine)
    );

    hart_matrix u_matrix (
        .clk      (clk),
        .quotient (quo),
        .sign     (sgn_dly_reg[S_DLY-1]),
        .cosine   (cs_dly_reg[C_DLY-1][63:32]),
        .sine     (cs_dly_reg[C_DLY-1][31:0]),
        .point    (p_dly_reg[P_DLY-1]),
        .zero     (zero_dly_reg[Z_DLY-1]),
        .rot      (rot),
        .shift    (shift)
    );

    assign r00 = rot[0];
    assign r01 = rot[1];
    assign r02 = rot[2];
    assign r10 = rot[3];
    assign r11 = rot[4];
    assign r12 = rot[5];
    assign r20 = rot[6];
    assign r21 = rot[7];
    assign r22 = rot[8];
    assign shift_x = shift[0];
    assign shift_y = shift[1];
    assign shift_z = shift[2];

    // A normalized radicand always yields a root with its top bit set.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4 + SQ] && !zero_dly_reg[2 + SQ] |-> root[31])
        else $error("square root lost its top bit");

    // Unit components never exceed one in Q30.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[T_Q-1] && !zero_dly_reg[Z_DLY-1] |->
            quo[0] <= 31'd1073741824 && quo[1] <= 31'd1073741824 &&
            quo[2] <= 31'd1073741824)
        else $error("unit vector component above one");

    // A zero direction leaves the identity and no translation.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(zero_dly_reg[Z_DLY-1], MT) |->
            r00 == 32'sd1073741824 && r01 == 32'sd0 && r22 == 32'sd1073741824 &&
            shift_x == 40'sd0 && shift_z == 40'sd0)
        else $error("zero direction did not give identity");

endmodule

`default_nettype wire

FILE: tb/hinge_axis_rigid_transform_checker.sv
// Checker for the hinge axis transform: watches start/busy and done, computes
// the expected rotation and translation per transaction and compares fields.
// Depends on hart_pkg for the output field types.
`timescale 1ns / 1ps

module hinge_axis_rigid_transform_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] turn_angle,
    input  logic               done,
    input  logic signed [31:0] r00,
    input  logic signed [31:0] r01,
    input  logic signed [31:0] r02,
    input  logic signed [31:0] r10,
    input  logic signed [31:0] r11,
    input  logic signed [31:0] r12,
    input  logic signed [31:0] r20,
    input  logic signed [31:0] r21,
    input  logic signed [31:0] r22,
    input  logic signed [39:0] shift_x,
    input  logic signed [39:0] shift_y,
    input  logic signed [39:0] shift_z,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        hart_pkg::q30_t  rot [9];
        hart_pkg::q16w_t shift [3];
    } transform_t;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint TWO_PI  = 64'sd6746518852;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint GAIN_INV = 64'sd652032874;

    transform_t expected_transforms[$];

    function automatic longint round_q30(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint arctan_step(int i);
        longint tbl [32] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
            'h00000001, 'h00000000};
        return tbl[i];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic transform_t predict_transform(logic signed [31:0] pin [3],
                                                     logic signed [31:0] din [3],
                                                     logic signed [31:0] ang);
        transform_t res;
        longint p [3];
        longint n [3];
        longint r [3][3];
        logic [63:0] mags [3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        longint a, x, y, z, xs, ys, c, s, cc, t;
        int k;
        bit neg;
        sum = 0;
        k = 0;
        neg = 0;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = pin[i];
            mags[i] = din[i] < 0 ? 64'(-longint'(din[i])) : 64'(longint'(din[i]));
            sum += mags[i] * mags[i];
        end
        if (sum == 0)
        begin
            for (int i = 0; i < 9; i++) res.rot[i] = (i % 4 == 0) ? 32'sd1073741824 : '0;
            for (int i = 0; i < 3; i++) res.shift[i] = '0;
            return res;
        end
        while (k < 31 && sum < (64'd1 << 62))
        begin
            sum <<= 2;
            k++;
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (((mags[i] << k) << 30) + (len >> 1)) / len;
            n[i] = din[i] < 0 ? -longint'(q) : longint'(q);
        end
        a = longint'(ang) * 4;
        if (a > PI_Q30) a -= TWO_PI;
        else if (a < -PI_Q30) a += TWO_PI;
        if (a > HALF_PI)
        begin
            a -= PI_Q30;
            neg = 1;
        end
        else if (a < -HALF_PI)
        begin
            a += PI_Q30;
            neg = 1;
        end
        x = GAIN_INV;
        y = 0;
        z = a;
        for (int i = 0; i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= arctan_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += arctan_step(i);
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
        cc = ONE_Q30 - c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r[i][j] = round_q30(round_q30(n[i], n[j]), cc) + (i == j ? c : 0);
        r[0][1] -= round_q30(n[2], s); r[1][0] += round_q30(n[2], s);
        r[0][2] += round_q30(n[1], s); r[2][0] -= round_q30(n[1], s);
        r[1][2] -= round_q30(n[0], s); r[2][1] += round_q30(n[0], s);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                if (r[i][j] > 64'sd2147483647) r[i][j] = 64'sd2147483647;
                if (r[i][j] < -64'sd2147483648) r[i][j] = -64'sd2147483648;
                res.rot[i * 3 + j] = 32'(r[i][j]);
            end
        for (int i = 0; i < 3; i++)
        begin
            t = p[i];
            for (int j = 0; j < 3; j++) t -= round_q30(r[i][j], p[j]);
            res.shift[i] = 40'(t);
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = expected_transforms.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        transform_t want;
        hart_pkg::q30_t got_rot [9];
        hart_pkg::q16w_t got_shift [3];
        if (rst_n && start && !busy)
            expected_transforms.insert(expected_transforms.size(),
                                       predict_transform('{point_x, point_y, point_z},
                                                         '{dir_x, dir_y, dir_z},
                                                         turn_angle));
        if (rst_n && done)
        begin
            got_rot = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
            got_shift = '{shift_x, shift_y, shift_z};
            if (expected_transforms.size() == 0)
                report_mismatch("unexpected transaction", 0, 0);
            else
            begin
                want = expected_transforms.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got_rot[i] !== want.rot[i])
                        report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                                        got_rot[i], want.rot[i]);
                for (int i = 0; i < 3; i++)
                    if (got_shift[i] !== want.shift[i])
                        report_mismatch($sformatf("shift[%0d]", i),
                                        got_shift[i], want.shift[i]);
            end
        end
    end

endmodule

FILE: tb/hinge_axis_rigid_transform_tb.sv
// Top of the hinge axis transform testbench: clock, reset, stimulus, verdict.
// Depends on hinge_axis_rigid_transform and hinge_axis_rigid_transform_checker.
`timescale 1ns / 1ps

module hinge_axis_rigid_transform_tb;

    localparam int LATENCY = 75;
    localparam int RANDOM_ITEMS = 1700;
    localparam longint CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic signed [31:0] point_x, point_y, point_z, dir_x, dir_y, dir_z, turn_angle;
    logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [39:0] shift_x, shift_y, shift_z;
    int fail_count;
    int pending;
    longint cycle_count;

    hinge_axis_rigid_transform dut (.*);
    hinge_axis_rigid_transform_checker checker_i (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 | $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 3) - 2;
            3: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    // After a random gap with start low, hold start for one transaction.
    task automatic send_transform(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                  logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                  logic [31:0] ang);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        point_x <= px; point_y <= py; point_z <= pz;
        dir_x <= dx; dir_y <= dy; dir_z <= dz;
        turn_angle <= ang;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial begin
        logic [31:0] angles [8];
        angles = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h3243F6A8, 32'hCDBC0958,
                   32'h1921FB54, 32'h6487ED51, 32'h9B7812AF};
        rst_n = 0;
        start = 0;
        {point_x, point_y, point_z, dir_x, dir_y, dir_z, turn_angle} = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // zero direction, axis-aligned and extreme directions, angles around pi
        send_transform(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 0, 0, 0, 32'h1000_0000);
        foreach (angles[i])
            send_transform($urandom, $urandom, $urandom, 32'h0001_0000, 0, 0, angles[i]);
        send_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_transform(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1, 0, 32'h1000_0000);
        send_transform(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 32'hFFFF_FFFF, 32'hF000_0000);
        send_transform(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 1, 1, 1, 32'h3243F6A9);
        send_transform(0, 0, 0, 32'h8000_0000, 0, 0, 32'hCDBC0957);
        // pause until the pipeline drains, then continue
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 400 < 40)
                send_transform($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom);
            else
                send_transform(rand_word(), rand_word(), rand_word(),
                               ($urandom_range(0, 9) == 0) ? 32'h0 : rand_word(),
                               rand_word(), rand_word(), rand_word());
        end
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
